FILE: hdl/jctfr_pkg.sv
// jctfr_pkg: shared types and constants for the job count table with free ring
// holds transaction payloads, command bundles and the sequencer state type
// no dependencies
package jctfr_pkg;

  // field widths fixed by the transaction format
  localparam int ID_BITS   = 16;
  localparam int CNT_BITS  = 16;
  localparam int SLOT_BITS = 4;

  // request transaction: optional head lookup plus optional new job
  typedef struct packed {
    logic                head_valid;
    logic [ID_BITS-1:0]  head_job_id;
    logic                new_valid;
    logic [ID_BITS-1:0]  new_id;
    logic [CNT_BITS-1:0] new_count;
  } req_t;

  // response transaction: lookup outcome and allocation outcome
  typedef struct packed {
    logic                 hit;
    logic                 invalidate;
    logic [ID_BITS-1:0]   hit_job_id;
    logic                 new_stored;
    logic [SLOT_BITS-1:0] stored_slot;
  } rsp_t;

  // slot table commands, all acting on the one shared slot address
  typedef struct packed {
    logic cnt_rd;
    logic cnt_wr;
    logic kill;
    logic alloc;
  } tbl_cmd_t;

  // free ring commands
  typedef struct packed {
    logic push;
    logic pop;
  } ring_cmd_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DEC,
    ST_POP,
    ST_FILL,
    ST_DONE
  } st_t;

endpackage

FILE: hdl/jctfr_req_if.sv
// jctfr_req_if: request channel, valid/ready handshake with a req_t payload
// depends on jctfr_pkg
interface jctfr_req_if;
  logic             valid;
  logic             ready;
  jctfr_pkg::req_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/jctfr_rsp_if.sv
// jctfr_rsp_if: response channel, valid/ready handshake with a rsp_t payload
// depends on jctfr_pkg
interface jctfr_rsp_if;
  logic             valid;
  logic             ready;
  jctfr_pkg::rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/job_count_table_with_free_ring_unit.sv
// job_count_table_with_free_ring_unit: top level, sequencer around the slot
// table and the free address ring
// depends on jctfr_pkg, jctfr_req_if, jctfr_rsp_if, jctfr_slot_table, jctfr_free_ring
//
//   port  dir  handshake     payload
//   req   in   valid/ready   head lookup and optional new job (req_t)
//   rsp   out  valid/ready   hit, invalidate, job id, store outcome (rsp_t)
//
// one request is in work at a time; the sequencer takes a scan and a
// decrement step for each matching slot, then a last scan, a pop step,
// a fill step when a new job pops the ring, and a done step. each match
// costs a read and a write back on the count memory; the ring pop costs
// one read of the ring memory. the result sits in an output register, so a
// stalled rsp only holds the sequencer once the following result is ready.
// rst is synchronous and needs no clearing pass.
module job_count_table_with_free_ring_unit #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  jctfr_req_if.sink          req,
  jctfr_rsp_if.source        rsp
);
  import jctfr_pkg::*;

  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RING_W = $clog2(SLOTS + 1);
  localparam logic [RING_W-1:0] LAST = RING_W'(SLOTS);

  st_t                 state;
  st_t                 state_next;
  req_t                item;
  logic [SLOTS-1:0]    pend;
  logic [ADDR_W-1:0]   cur;
  logic [ADDR_W-1:0]   pick;
  logic                hit;
  logic                inval;
  logic                stored;
  logic [ADDR_W-1:0]   slot;
  logic                out_valid;
  rsp_t                out_data;
  logic                out_free;

  tbl_cmd_t            tbl_cmd;
  logic [ADDR_W-1:0]   tbl_addr;
  logic [SLOTS-1:0]    match;
  logic [CNT_BITS-1:0] wr_cnt;
  logic [CNT_BITS-1:0] rd_cnt;
  logic [CNT_BITS-1:0] dec;
  logic                dec_zero;

  ring_cmd_t           ring_cmd;
  logic                ring_empty;
  logic [RING_W-1:0]   pop_ent;
  logic                fill_ok;
  logic [ADDR_W-1:0]   fill_addr;

  jctfr_slot_table #(.SLOTS(SLOTS)) u_table (
    .clk     (clk),
    .rst     (rst),
    .cmd     (tbl_cmd),
    .addr    (tbl_addr),
    .look_id (req.data.head_job_id),
    .match   (match),
    .wr_id   (item.new_id),
    .wr_cnt  (wr_cnt),
    .rd_cnt  (rd_cnt)
  );

  jctfr_free_ring #(.SLOTS(SLOTS)) u_ring (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ring_cmd),
    .push_addr (cur),
    .empty     (ring_empty),
    .pop_ent   (pop_ent)
  );

  // lowest pending match, so slots are visited in ascending order
  always_comb begin
    pick = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        pick = ADDR_W'(i);
      end
    end
  end

  // decrement wraps, so a zero count becomes all ones and does not free the slot
  assign dec       = rd_cnt - CNT_BITS'(1);
  assign dec_zero  = (dec == '0);
  assign fill_ok   = (pop_ent < LAST);
  assign fill_addr = ADDR_W'(pop_ent);
  assign out_free  = !out_valid || rsp.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (req.valid) state_next = ST_SCAN;
      ST_SCAN: state_next = (|pend) ? ST_DEC : ST_POP;
      ST_DEC:  state_next = ST_SCAN;
      ST_POP:  state_next = (item.new_valid && !ring_empty) ? ST_FILL : ST_DONE;
      ST_FILL: state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req.ready = 1'b0;
    tbl_cmd   = '0;
    tbl_addr  = cur;
    wr_cnt    = dec;
    ring_cmd  = '0;
    case (state)
      ST_IDLE: req.ready = 1'b1;
      ST_SCAN: begin
        tbl_cmd.cnt_rd = |pend;
        tbl_addr       = pick;
      end
      ST_DEC: begin
        tbl_cmd.cnt_wr = 1'b1;
        tbl_cmd.kill   = dec_zero;
        ring_cmd.push  = dec_zero;
      end
      ST_POP: ring_cmd.pop = item.new_valid && !ring_empty;
      ST_FILL: begin
        tbl_addr       = fill_addr;
        wr_cnt         = item.new_count;
        tbl_cmd.cnt_wr = fill_ok;
        tbl_cmd.alloc  = fill_ok;
      end
      default: begin
        tbl_addr = cur;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // per-transaction working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          item   <= req.data;
          pend   <= req.data.head_valid ? match : '0;
          hit    <= 1'b0;
          inval  <= 1'b0;
          stored <= 1'b0;
          slot   <= '0;
        end
      end
      ST_SCAN: begin
        if (|pend) begin
          cur        <= pick;
          pend[pick] <= 1'b0;
        end
      end
      ST_DEC: begin
        hit   <= 1'b1;
        inval <= dec_zero;
      end
      ST_FILL: begin
        if (fill_ok) begin
          stored <= 1'b1;
          slot   <= fill_addr;
        end
      end
      default: begin
        hit <= hit;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_data.hit         <= hit;
      out_data.invalidate  <= inval;
      out_data.hit_job_id  <= hit ? item.head_job_id : '0;
      out_data.new_stored  <= stored;
      out_data.stored_slot <= SLOT_BITS'(slot);
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // pending matches are only loaded at acceptance, never regained mid work
  a_pend_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |=> ((pend & ~$past(pend)) == '0))
    else $error("pending match set grew during a transaction");

  // a result appears only after the sequencer has finished
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("response raised outside the done state");

  // invalidate only with a hit, no slot number without a store
  a_rsp_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.hit || !out_data.invalidate) &&
                   (out_data.new_stored || (out_data.stored_slot == '0))))
    else $error("inconsistent response fields");

endmodule

FILE: hdl/jctfr_slot_table.sv
// jctfr_slot_table: associative job id match over valid slots, plus the
// remaining count store as a synchronous memory with a registered read
// depends on jctfr_pkg
module jctfr_slot_table #(
  parameter int SLOTS = 16,
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  jctfr_pkg::tbl_cmd_t          cmd,
  input  logic [ADDR_W-1:0]            addr,
  input  logic [jctfr_pkg::ID_BITS-1:0]  look_id,
  output logic [SLOTS-1:0]             match,
  input  logic [jctfr_pkg::ID_BITS-1:0]  wr_id,
  input  logic [jctfr_pkg::CNT_BITS-1:0] wr_cnt,
  output logic [jctfr_pkg::CNT_BITS-1:0] rd_cnt
);
  import jctfr_pkg::*;

  logic [SLOTS-1:0]   slot_valid;
  logic [ID_BITS-1:0] slot_job_id [SLOTS];
  logic [CNT_BITS-1:0] cnt_mem [SLOTS];

  // parallel compare of every valid slot against the lookup id
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = slot_valid[i] && (slot_job_id[i] == look_id);
    end
  end

  // valid bits: set on allocation, cleared when the count runs out
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.alloc) begin
      slot_valid[addr] <= 1'b1;
    end else if (cmd.kill) begin
      slot_valid[addr] <= 1'b0;
    end
  end

  // id cells, written on allocation only
  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      slot_job_id[addr] <= wr_id;
    end
  end

  // count memory, one port, registered read
  always_ff @(posedge clk) begin
    if (cmd.cnt_wr) begin
      cnt_mem[addr] <= wr_cnt;
    end
    if (cmd.cnt_rd) begin
      rd_cnt <= cnt_mem[addr];
    end
  end

endmodule

FILE: hdl/jctfr_free_ring.sv
// jctfr_free_ring: ring of free slot addresses with one spare place, held in
// a synchronous memory; entries never written read as their own index
// depends on jctfr_pkg
module jctfr_free_ring #(
  parameter int SLOTS = 16,
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int RING_W = $clog2(SLOTS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  jctfr_pkg::ring_cmd_t cmd,
  input  logic [ADDR_W-1:0]   push_addr,
  output logic                empty,
  output logic [RING_W-1:0]   pop_ent
);
  import jctfr_pkg::*;

  localparam logic [RING_W-1:0] LAST = RING_W'(SLOTS);

  logic [ADDR_W-1:0] ring_mem [SLOTS+1];
  logic [SLOTS:0]    written;
  logic [RING_W-1:0] head;
  logic [RING_W-1:0] tail;
  logic [RING_W-1:0] push_idx;
  logic              push_ok;
  logic [ADDR_W-1:0] rd_data;
  logic              rd_written;
  logic [RING_W-1:0] rd_idx;

  // push place and full check; the last place wraps the tail to zero
  always_comb begin
    if (tail >= LAST) begin
      push_idx = LAST;
      push_ok  = (head != '0);
    end else begin
      push_idx = tail;
      push_ok  = ((tail + RING_W'(1)) != head);
    end
  end

  assign empty = (head == tail);

  // head and tail pointers, plus written marks for the reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= LAST;
      written <= '0;
    end else begin
      if (cmd.push && push_ok) begin
        written[push_idx] <= 1'b1;
        tail <= (tail >= LAST) ? '0 : tail + RING_W'(1);
      end
      if (cmd.pop) begin
        head <= (head >= LAST) ? '0 : head + RING_W'(1);
      end
    end
  end

  // ring memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.push && push_ok) begin
      ring_mem[push_idx] <= push_addr;
    end
    if (cmd.pop) begin
      rd_data    <= ring_mem[head];
      rd_written <= written[head];
      rd_idx     <= head;
    end
  end

  // an entry never written stands for its own index
  assign pop_ent = rd_written ? RING_W'(rd_data) : rd_idx;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for job_count_table_with_free_ring_unit
// directed and random head/new job transactions checked against a local table model
// depends on jctfr_pkg, jctfr_req_if, jctfr_rsp_if and the unit itself
module testbench;
  import jctfr_pkg::*;

  localparam int SLOTS        = 16;
  localparam int IDLE_LIMIT   = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 625;

  logic clk = 1'b0;
  logic rst;

  jctfr_req_if req_ch();
  jctfr_rsp_if rsp_ch();

  job_count_table_with_free_ring_unit #(.SLOTS(SLOTS)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // local copy of the slot table and the free address ring
  logic                tab_valid [SLOTS];
  logic [ID_BITS-1:0]  tab_id    [SLOTS];
  logic [CNT_BITS-1:0] tab_cnt   [SLOTS];
  logic [4:0]          ring_addr [SLOTS+1];
  int                  ring_rd;
  int                  ring_wr;

  rsp_t pending_outcomes[$];
  int   mismatch_count = 0;
  bit   calm = 1'b0;
  int   sink_wait = 0;
  int   idle_cycles = 0;

  always #6 clk = ~clk;

  // lookup, decrement and free, then allocate from the ring
  function automatic rsp_t predict_outcome(input req_t r);
    rsp_t o;
    int   addr;
    o = '0;
    if (r.head_valid) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (tab_valid[i] && tab_id[i] == r.head_job_id) begin
          tab_cnt[i]   = tab_cnt[i] - CNT_BITS'(1);
          o.hit        = 1'b1;
          o.hit_job_id = r.head_job_id;
          if (tab_cnt[i] == '0) begin
            tab_valid[i] = 1'b0;
            o.invalidate = 1'b1;
            // push the freed address, ignored when the ring is full
            if (ring_wr >= SLOTS) begin
              if (ring_rd != 0) begin
                ring_addr[SLOTS] = 5'(i);
                ring_wr = 0;
              end
            end else if (ring_wr + 1 != ring_rd) begin
              ring_addr[ring_wr] = 5'(i);
              ring_wr = ring_wr + 1;
            end
          end else begin
            o.invalidate = 1'b0;
          end
        end
      end
    end
    // pop happens after the push, so a slot freed here can be reused at once
    if (r.new_valid && ring_rd != ring_wr) begin
      addr    = int'(ring_addr[ring_rd]);
      ring_rd = (ring_rd >= SLOTS) ? 0 : ring_rd + 1;
      if (addr < SLOTS) begin
        tab_valid[addr] = 1'b1;
        tab_id[addr]    = r.new_id;
        tab_cnt[addr]   = r.new_count;
        o.new_stored    = 1'b1;
        o.stored_slot   = SLOT_BITS'(addr);
      end
    end
    return o;
  endfunction

  function automatic req_t mk_req(input logic hv, input logic [ID_BITS-1:0] hid,
                                  input logic nv, input logic [ID_BITS-1:0] nid,
                                  input logic [CNT_BITS-1:0] ncnt);
    req_t r;
    r.head_valid  = hv;
    r.head_job_id = hid;
    r.new_valid   = nv;
    r.new_id      = nid;
    r.new_count   = ncnt;
    return r;
  endfunction

  function automatic bit field_differs(input string name, input int unsigned want,
                                       input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // one request transaction: idle gap, hold valid until accepted, then predict
  task automatic send_tick(input req_t item);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= item;
    do @(posedge clk); while (!req_ch.ready);
    pending_outcomes.push_back(predict_outcome(item));
  endtask

  // response sink: random stalls per transaction, compare with oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    bit   bad;
    int   w;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      sink_wait = 0;
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: response expected none, actual %0h", $time, rsp_ch.data);
        mismatch_count++;
      end else begin
        want = pending_outcomes.pop_front();
        bad  = field_differs("hit", 32'(want.hit), 32'(rsp_ch.data.hit))
             | field_differs("invalidate", 32'(want.invalidate),
                             32'(rsp_ch.data.invalidate))
             | field_differs("hit_job_id", 32'(want.hit_job_id),
                             32'(rsp_ch.data.hit_job_id))
             | field_differs("new_stored", 32'(want.new_stored),
                             32'(rsp_ch.data.new_stored))
             | field_differs("stored_slot", 32'(want.stored_slot),
                             32'(rsp_ch.data.stored_slot));
        if (bad) mismatch_count++;
      end
      w = calm ? 0 : $urandom_range(0, 7);
      if (w > 0) begin
        rsp_ch.ready <= 1'b0;
        sink_wait = w - 1;
      end
    end else if (!rsp_ch.ready) begin
      if (sink_wait == 0) rsp_ch.ready <= 1'b1;
      else sink_wait--;
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // lookups on an empty table must miss, id zero included; idle ticks do nothing
  task automatic test_empty_table();
    calm = 1'b1;
    send_tick(mk_req(1'b1, 16'h0000, 1'b0, 16'hFFFF, 16'hFFFF));
    send_tick(mk_req(1'b1, 16'hFFFF, 1'b0, 16'h0000, 16'h0001));
    send_tick(mk_req(1'b0, 16'h0000, 1'b0, 16'hFFFF, 16'h0000));
    calm = 1'b0;
  endtask

  // fill every slot, drop on an empty ring, then multiple matches and reuse
  task automatic test_fill_and_drop();
    send_tick(mk_req(1'b0, 16'h0000, 1'b1, 16'h0000, 16'h0001));
    send_tick(mk_req(1'b0, 16'h0000, 1'b1, 16'hFFFF, 16'hFFFF));
    // zero count wraps on its first decrement
    send_tick(mk_req(1'b0, 16'h0000, 1'b1, 16'hA5A5, 16'h0000));
    // three copies of one id, highest slot survives the first lookup
    send_tick(mk_req(1'b0, 16'h0000, 1'b1, 16'h1234, 16'h0001));
    send_tick(mk_req(1'b0, 16'h0000, 1'b1, 16'h1234, 16'h0001));
    send_tick(mk_req(1'b0, 16'h0000, 1'b1, 16'h1234, 16'h0002));
    for (int k = 6; k < SLOTS; k++)
      send_tick(mk_req(1'b0, 16'h0000, 1'b1, 16'h0100 + 16'(k), 16'h0001));
    // ring empty: new job dropped
    send_tick(mk_req(1'b0, 16'h0000, 1'b1, 16'h5A5A, 16'hFFFF));
    // two slots freed, new job takes one of them in the same transaction
    send_tick(mk_req(1'b1, 16'h1234, 1'b1, 16'h4321, 16'h0003));
    send_tick(mk_req(1'b1, 16'hA5A5, 1'b0, 16'h0000, 16'h0000));
    send_tick(mk_req(1'b1, 16'hFFFF, 1'b0, 16'h0000, 16'h0000));
    send_tick(mk_req(1'b1, 16'h0000, 1'b0, 16'h0000, 16'h0000));
    send_tick(mk_req(1'b1, 16'h1234, 1'b0, 16'h0000, 16'h0000));
  endtask

  // mostly lookups of stored ids over a small id pool, with misses and drops
  task automatic test_random_traffic();
    logic                hv, nv;
    logic [ID_BITS-1:0]  hid, nid;
    logic [CNT_BITS-1:0] ncnt;
    int                  sel, k, new_pct;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm    = (n % 100) < 25;
      new_pct = ((n % 200) < 100) ? 30 : 60;
      // hold off until the table has answered everything sent so far
      if (n == RANDOM_ITEMS / 2) begin
        req_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
      end
      hv  = $urandom_range(0, 99) < 85;
      sel = $urandom_range(0, 99);
      hid = ID_BITS'($urandom);
      if (sel < 15) hid = ID_BITS'($urandom_range(0, 7));
      else if (sel < 85) begin
        k = $urandom_range(0, SLOTS - 1);
        for (int j = 0; j < SLOTS; j++) begin
          if (tab_valid[(k + j) % SLOTS]) begin
            hid = tab_id[(k + j) % SLOTS];
            break;
          end
        end
      end
      nv  = $urandom_range(0, 99) < new_pct;
      nid = $urandom_range(0, 1) ? ID_BITS'($urandom) : ID_BITS'($urandom_range(0, 7));
      // wide counts mostly where the ring is empty and the job is dropped
      if (ring_rd == ring_wr) ncnt = CNT_BITS'($urandom);
      else if ($urandom_range(0, 7) == 0) ncnt = CNT_BITS'($urandom_range(1, 16));
      else ncnt = CNT_BITS'($urandom_range(1, 4));
      send_tick(mk_req(hv, hid, nv, nid, ncnt));
    end
  endtask

  initial begin
    rst           = 1'b1;
    req_ch.valid  = 1'b0;
    req_ch.data   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tab_valid[i] = 1'b0;
      tab_id[i]    = '0;
      tab_cnt[i]   = '0;
    end
    for (int i = 0; i <= SLOTS; i++) ring_addr[i] = 5'(i);
    ring_rd = 0;
    ring_wr = SLOTS;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_fill_and_drop();
    test_random_traffic();

    // drain outstanding responses, then let the unit settle
    req_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/jctfr_pkg.sv
hdl/jctfr_req_if.sv
hdl/jctfr_rsp_if.sv
hdl/jctfr_slot_table.sv
hdl/jctfr_free_ring.sv
hdl/job_count_table_with_free_ring_unit.sv
tb/sv/testbench.sv
